// File: rtl/pta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pta_pkg
// Types and constants shared by the peer table with aging.
// ----------------------------------------------------------------------------
package pta_pkg;

  localparam int unsigned KEY_W     = 48;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned RSSI_W    = 8;
  localparam int unsigned EVENT_W   = 3;
  localparam int unsigned SLOT_IDX_W = 4;

  localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd5000;

  // Operation codes of a command beat
  localparam logic OP_SIGHT = 1'b0;
  localparam logic OP_AGE   = 1'b1;

  // Event codes of a result beat
  localparam logic [EVENT_W-1:0] EV_REFRESH = 3'd0;
  localparam logic [EVENT_W-1:0] EV_NEW     = 3'd1;
  localparam logic [EVENT_W-1:0] EV_DROP    = 3'd2;
  localparam logic [EVENT_W-1:0] EV_LOST    = 3'd3;
  localparam logic [EVENT_W-1:0] EV_DONE    = 3'd4;

  typedef struct packed {
    logic                     op;
    logic [KEY_W-1:0]         peer_key;
    logic signed [RSSI_W-1:0] rssi;
    logic [TIME_W-1:0]        now_ms;
  } cmd_t;

  typedef struct packed {
    logic [EVENT_W-1:0]       event_res;
    logic [SLOT_IDX_W-1:0]    slot_index;
    logic [KEY_W-1:0]         key_out;
    logic signed [RSSI_W-1:0] rssi_out;
    logic                     any_active;
    logic                     last;
  } res_t;

  // Verdict on one slot from the shared evaluation unit
  typedef struct packed {
    logic match;
    logic free;
    logic expired;
  } slot_eval_t;

endpackage

// File: rtl/peer_table_with_aging.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// peer_table_with_aging
// Small peer table: sightings refresh or claim slots, age passes drop stale
// peers. One slot is visited per cycle through a shared evaluation unit.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                         Beat moves when
//  -------  ----------------------------  ---------------------------------
//  command  start, busy, cmd              start && !busy
//  result   res_valid, res                res_valid (one cycle, no stall)
//  config   cfg_valid, cfg_ready, cfg_data cfg_valid && cfg_ready (idle only)
//
//  A sighting scans slots in order, one per cycle, and stops on the first
//  active key match; a new command is taken only once the block is idle.
//  An age pass checks every slot, then emits the lost peers in slot order,
//  then gives one summary beat; a new command is taken only once it ends.
//  Synchronous reset clears the active marks of all slots and loads the default timeout.
//  The result side cannot stall; each result beat shows for one cycle.
//
module peer_table_with_aging #(
  parameter int SLOT_COUNT = 4,
  parameter int KEY_BITS   = 48
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  pta_pkg::cmd_t               cmd,
  output logic                        res_valid,
  output pta_pkg::res_t               res,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pta_pkg::TIME_W-1:0]  cfg_data
);
  import pta_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  // Sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;  // sighting: look for match / free slot
  localparam logic [2:0] ST_CHK  = 3'd2;  // age: mark expired slots
  localparam logic [2:0] ST_EMIT = 3'd3;  // age: report lost slots in order
  localparam logic [2:0] ST_DONE = 3'd4;  // age: summary beat

  logic [2:0] state;
  logic [IDX_W-1:0] idx;

  // Slot storage; only the active marks need reset
  logic [KEY_BITS-1:0] slot_key  [SLOT_COUNT];
  logic [RSSI_W-1:0]   slot_rssi [SLOT_COUNT];
  logic [TIME_W-1:0]   slot_seen [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_active;

  logic [TIME_W-1:0] timeout;

  // Latched command
  logic [KEY_BITS-1:0] key_q;
  logic [RSSI_W-1:0]   rssi_q;
  logic [TIME_W-1:0]   now_q;

  // Scan bookkeeping
  logic                  have_free;
  logic [IDX_W-1:0]      first_free;
  logic [SLOT_COUNT-1:0] lost;
  logic                  keep;   // some slot survives the age pass

  slot_eval_t verdict;
  logic [IDX_W-1:0] claim_idx;
  logic can_claim;

  pta_slot_eval #(
    .KEY_BITS (KEY_BITS)
  ) u_eval (
    .slot_active (slot_active[idx]),
    .slot_key    (slot_key[idx]),
    .slot_seen   (slot_seen[idx]),
    .item_key    (key_q),
    .now_ms      (now_q),
    .timeout     (timeout),
    .verdict     (verdict)
  );

  // First free slot seen so far, including the one under the scan
  assign can_claim = have_free || verdict.free;
  assign claim_idx = have_free ? first_free : idx;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = !busy;

  // Timeout register: written only while idle
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout <= cfg_data;
    end
  end

  // Sequencer, slot updates and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      idx         <= '0;
      slot_active <= '0;
      res_valid   <= 1'b0;
      have_free   <= 1'b0;
      lost        <= '0;
      keep        <= 1'b0;
    end else begin
      res_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            key_q     <= cmd.peer_key[KEY_BITS-1:0];
            rssi_q    <= cmd.rssi;
            now_q     <= cmd.now_ms;
            idx       <= '0;
            have_free <= 1'b0;
            lost      <= '0;
            keep      <= 1'b0;
            state     <= (cmd.op == OP_AGE) ? ST_CHK : ST_SCAN;
          end
        end

        ST_SCAN: begin
          // Sighting always leaves at least one slot active
          res.key_out    <= KEY_W'(key_q);
          res.rssi_out   <= rssi_q;
          res.any_active <= 1'b1;
          res.last       <= 1'b1;
          if (verdict.match) begin
            slot_rssi[idx] <= rssi_q;
            slot_seen[idx] <= now_q;
            res.event_res  <= EV_REFRESH;
            res.slot_index <= SLOT_IDX_W'(idx);
            res_valid      <= 1'b1;
            state          <= ST_IDLE;
          end else if (idx == LAST_IDX) begin
            if (can_claim) begin
              slot_active[claim_idx] <= 1'b1;
              slot_key[claim_idx]    <= key_q;
              slot_rssi[claim_idx]   <= rssi_q;
              slot_seen[claim_idx]   <= now_q;
              res.event_res          <= EV_NEW;
              res.slot_index         <= SLOT_IDX_W'(claim_idx);
            end else begin
              res.event_res  <= EV_DROP;
              res.slot_index <= '0;
            end
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end else begin
            if (verdict.free && !have_free) begin
              have_free  <= 1'b1;
              first_free <= idx;
            end
            idx <= idx + 1'b1;
          end
        end

        ST_CHK: begin
          // Drop the active mark now; key and rssi stay for reporting
          if (verdict.expired) begin
            lost[idx]        <= 1'b1;
            slot_active[idx] <= 1'b0;
          end else if (!verdict.free) begin
            keep <= 1'b1;
          end
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= ST_EMIT;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        ST_EMIT: begin
          res.event_res  <= EV_LOST;
          res.slot_index <= SLOT_IDX_W'(idx);
          res.key_out    <= KEY_W'(slot_key[idx]);
          res.rssi_out   <= slot_rssi[idx];
          res.any_active <= keep;
          res.last       <= 1'b0;
          res_valid      <= lost[idx];
          if (idx == LAST_IDX) begin
            state <= ST_DONE;
          end else begin
            idx <= idx + 1'b1;
          end
        end

        ST_DONE: begin
          res.event_res  <= EV_DONE;
          res.slot_index <= '0;
          res.key_out    <= '0;
          res.rssi_out   <= '0;
          res.any_active <= keep;
          res.last       <= 1'b1;
          res_valid      <= 1'b1;
          state          <= ST_IDLE;
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // An accepted command always occupies the sequencer for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command accepted but block not busy");

  // A non-final result beat comes while the age pass is still running
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.last) |-> busy)
    else $error("non-final result beat while idle");

  // The age summary always closes its command
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.event_res == EV_DONE) |-> res.last)
    else $error("age summary without last");

  // A refreshed or newly seen peer implies the table is not empty
  a_sight_active: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res.event_res == EV_REFRESH || res.event_res == EV_NEW))
      |-> (res.any_active && slot_active != '0))
    else $error("sighting result with empty table");

endmodule

// File: rtl/pta_slot_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pta_slot_eval
// Shared per-slot unit: key compare and modular age check of one slot.
// ----------------------------------------------------------------------------
module pta_slot_eval #(
  parameter int KEY_BITS = 48
) (
  input  logic                        slot_active,
  input  logic [KEY_BITS-1:0]         slot_key,
  input  logic [pta_pkg::TIME_W-1:0]  slot_seen,
  input  logic [KEY_BITS-1:0]         item_key,
  input  logic [pta_pkg::TIME_W-1:0]  now_ms,
  input  logic [pta_pkg::TIME_W-1:0]  timeout,
  output pta_pkg::slot_eval_t         verdict
);
  import pta_pkg::*;

  logic [TIME_W-1:0] age;

  // Wrap-safe elapsed time
  assign age = now_ms - slot_seen;

  assign verdict.match   = slot_active && (slot_key == item_key);
  assign verdict.free    = !slot_active;
  assign verdict.expired = slot_active && (age >= timeout);

endmodule
